@@ hw/rtl/pftp_pkg.sv @@
// ----------------------------------------------------------------------------
// pftp_pkg
// shared widths and types for the plane-from-three-points pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package pftp_pkg;

   // result field widths
   localparam int NORMAL_W = 16;
   localparam int OFFSET_W = 27;

   // normalized cross-product magnitude: top bit sits at MAG_TOP
   localparam int MAG_W   = 31;
   localparam int MAG_TOP = 30;

   // sum of squares and its integer root
   localparam int SUM_W  = 64;
   localparam int ROOT_W = 32;

   // register stages in the front end and the back end
   localparam int FRONT_STAGES = 8;
   localparam int BACK_STAGES  = 4;

   typedef logic [MAG_W-1:0]  mag_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [ROOT_W-1:0] root_type;

endpackage

`default_nettype wire

@@ hw/rtl/pftp_front.sv @@
// ----------------------------------------------------------------------------
// pftp_front
// edge vectors, cross product, common normalizing shift and sum of squares
// ----------------------------------------------------------------------------
`default_nettype none

module pftp_front
   import pftp_pkg::*;
#(
   parameter int COORD_BITS = 24
)
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   input  wire signed [COORD_BITS-1:0] a_x,
   input  wire signed [COORD_BITS-1:0] a_y,
   input  wire signed [COORD_BITS-1:0] a_z,
   input  wire signed [COORD_BITS-1:0] b_x,
   input  wire signed [COORD_BITS-1:0] b_y,
   input  wire signed [COORD_BITS-1:0] b_z,
   input  wire signed [COORD_BITS-1:0] c_x,
   input  wire signed [COORD_BITS-1:0] c_y,
   input  wire signed [COORD_BITS-1:0] c_z,
   output logic                        out_valid,
   output sum_type                     out_sum,
   output mag_type [2:0]               out_mag,
   output logic [2:0]                  out_neg,
   output logic                        out_degen,
   output logic signed [COORD_BITS-1:0] out_a_x,
   output logic signed [COORD_BITS-1:0] out_a_y,
   output logic signed [COORD_BITS-1:0] out_a_z
);

   localparam int EW = COORD_BITS + 1;

   // position of the highest set bit
   function automatic logic [6:0] lead_one(input logic [62:0] v);
      logic [6:0] idx;
      idx = '0;
      for (int i = 0; i < 63; i++) begin
         if (v[i]) idx = 7'(i);
      end
      return idx;
   endfunction

   function automatic logic signed [EW-1:0] sx(input logic [COORD_BITS-1:0] v);
      return $signed({v[COORD_BITS-1], v});
   endfunction

   logic [FRONT_STAGES-1:0]      valid_ff;
   logic signed [COORD_BITS-1:0] a_ff [FRONT_STAGES][3];

   logic signed [EW-1:0] edge1_ff [6];
   logic signed [31:0]   edge2_ff [6];
   logic signed [63:0]   prod3_ff [6];
   logic signed [63:0]   cross4_ff [3];
   logic [62:0]          cmag5_ff [3];
   logic [6:0]           lead5_ff;
   mag_type              m6_ff [3];
   mag_type              m7_ff [3];
   mag_type              m8_ff [3];
   logic [61:0]          sq7_ff [3];
   sum_type              sum8_ff;
   logic [2:0]           neg5_ff, neg6_ff, neg7_ff, neg8_ff;
   logic                 degen5_ff, degen6_ff, degen7_ff, degen8_ff;

   logic signed [EW-1:0] edge1_in [6];
   logic signed [31:0]   edge2_in [6];
   logic [62:0]          cmag5_in [3];
   logic [6:0]           lead5_in;
   logic [2:0]           neg5_in;
   mag_type              m6_in [3];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   // first point travels alongside
   always_ff @(posedge clock) begin
      a_ff[0][0] <= a_x;
      a_ff[0][1] <= a_y;
      a_ff[0][2] <= a_z;
      for (int s = 1; s < FRONT_STAGES; s++) begin
         a_ff[s] <= a_ff[s-1];
      end
   end

   // stage 1: edge vectors
   always_comb begin
      edge1_in[0] = sx(b_x) - sx(a_x);
      edge1_in[1] = sx(b_y) - sx(a_y);
      edge1_in[2] = sx(b_z) - sx(a_z);
      edge1_in[3] = sx(c_x) - sx(a_x);
      edge1_in[4] = sx(c_y) - sx(a_y);
      edge1_in[5] = sx(c_z) - sx(a_z);
   end

   always_ff @(posedge clock) begin
      edge1_ff <= edge1_in;
   end

   // stage 2: common right shift keeps every edge below 2^31
   always_comb begin
      logic [EW-1:0] emag [6];
      logic [EW-1:0] orv;
      logic [6:0]    lead;
      logic [6:0]    sh;
      mag_type       smag;
      orv = '0;
      for (int i = 0; i < 6; i++) begin
         emag[i] = edge1_ff[i][EW-1] ? EW'(-edge1_ff[i]) : EW'(edge1_ff[i]);
         orv     = orv | emag[i];
      end
      lead = lead_one(63'(orv));
      sh   = (lead > 7'(MAG_TOP)) ? lead - 7'(MAG_TOP) : '0;
      for (int i = 0; i < 6; i++) begin
         smag = MAG_W'(emag[i] >> sh);
         edge2_in[i] = edge1_ff[i][EW-1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
      end
   end

   always_ff @(posedge clock) begin
      edge2_ff <= edge2_in;
   end

   // stage 3: six partial products
   always_ff @(posedge clock) begin
      prod3_ff[0] <= edge2_ff[1] * edge2_ff[5];
      prod3_ff[1] <= edge2_ff[2] * edge2_ff[4];
      prod3_ff[2] <= edge2_ff[2] * edge2_ff[3];
      prod3_ff[3] <= edge2_ff[0] * edge2_ff[5];
      prod3_ff[4] <= edge2_ff[0] * edge2_ff[4];
      prod3_ff[5] <= edge2_ff[1] * edge2_ff[3];
   end

   // stage 4: cross product
   always_ff @(posedge clock) begin
      cross4_ff[0] <= prod3_ff[0] - prod3_ff[1];
      cross4_ff[1] <= prod3_ff[2] - prod3_ff[3];
      cross4_ff[2] <= prod3_ff[4] - prod3_ff[5];
   end

   // stage 5: magnitudes, signs and leading one of the largest
   always_comb begin
      logic [62:0] orv;
      orv = '0;
      for (int i = 0; i < 3; i++) begin
         neg5_in[i]  = cross4_ff[i][63];
         cmag5_in[i] = neg5_in[i] ? 63'(-cross4_ff[i]) : cross4_ff[i][62:0];
         orv         = orv | cmag5_in[i];
      end
      lead5_in = lead_one(orv);
   end

   always_ff @(posedge clock) begin
      cmag5_ff  <= cmag5_in;
      lead5_ff  <= lead5_in;
      neg5_ff   <= neg5_in;
      degen5_ff <= (cmag5_in[0] == '0) && (cmag5_in[1] == '0) && (cmag5_in[2] == '0);
   end

   // stage 6: largest magnitude brought into [2^30, 2^31)
   always_comb begin
      logic [62:0] shifted;
      for (int i = 0; i < 3; i++) begin
         if (lead5_ff >= 7'(MAG_TOP)) begin
            shifted = cmag5_ff[i] >> (lead5_ff - 7'(MAG_TOP));
         end else begin
            shifted = cmag5_ff[i] << (7'(MAG_TOP) - lead5_ff);
         end
         m6_in[i] = shifted[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      m6_ff     <= m6_in;
      neg6_ff   <= neg5_ff;
      degen6_ff <= degen5_ff;
   end

   // stage 7: squares
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq7_ff[i] <= m6_ff[i] * m6_ff[i];
      end
      m7_ff     <= m6_ff;
      neg7_ff   <= neg6_ff;
      degen7_ff <= degen6_ff;
   end

   // stage 8: sum of squares
   always_ff @(posedge clock) begin
      sum8_ff   <= SUM_W'(sq7_ff[0]) + SUM_W'(sq7_ff[1]) + SUM_W'(sq7_ff[2]);
      m8_ff     <= m7_ff;
      neg8_ff   <= neg7_ff;
      degen8_ff <= degen7_ff;
   end

   assign out_valid  = valid_ff[FRONT_STAGES-1];
   assign out_sum    = sum8_ff;
   assign out_mag[0] = m8_ff[0];
   assign out_mag[1] = m8_ff[1];
   assign out_mag[2] = m8_ff[2];
   assign out_neg    = neg8_ff;
   assign out_degen  = degen8_ff;
   assign out_a_x    = a_ff[FRONT_STAGES-1][0];
   assign out_a_y    = a_ff[FRONT_STAGES-1][1];
   assign out_a_z    = a_ff[FRONT_STAGES-1][2];

endmodule

`default_nettype wire

@@ hw/rtl/pftp_isqrt.sv @@
// ----------------------------------------------------------------------------
// pftp_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module pftp_isqrt
   import pftp_pkg::*;
#(
   parameter int SIDE_W = 8
)
(
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   input  wire [SUM_W-1:0]   in_sum,
   input  wire [SIDE_W-1:0]  in_side,
   output logic              out_valid,
   output root_type          out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STEPS = ROOT_W;
   localparam int REM_W = ROOT_W + 4;

   logic [STEPS-1:0]  valid_ff;
   logic [REM_W-1:0]  rem_ff  [STEPS];
   root_type          root_ff [STEPS];
   sum_type           x_ff    [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STEPS-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [REM_W-1:0]  rem_prev;
      root_type          root_prev;
      sum_type           x_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W-1:0]  rem_in;
      root_type          root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = in_sum;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign x_prev    = x_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // bring down two bits and try the next root bit
      always_comb begin
         logic [REM_W-1:0] rem_sh;
         logic [REM_W-1:0] trial;
         rem_sh = {rem_prev[REM_W-3:0], x_prev[SUM_W-1 -: 2]};
         trial  = REM_W'({root_prev, 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         x_ff[k]    <= x_prev << 2;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

@@ hw/rtl/pftp_div.sv @@
// ----------------------------------------------------------------------------
// pftp_div
// three-lane pipelined rounding divider by the norm, one quotient bit a stage
// ----------------------------------------------------------------------------
`default_nettype none

module pftp_div
   import pftp_pkg::*;
#(
   parameter int FRAC_BITS = 14,
   parameter int SIDE_W    = 8
)
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  wire [ROOT_W-1:0]        in_root,
   input  wire [2:0][MAG_W-1:0]    in_mag,
   input  wire [SIDE_W-1:0]        in_side,
   output logic                    out_valid,
   output logic [2:0][FRAC_BITS:0] out_quot,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int QB    = FRAC_BITS + 1;
   localparam int XW    = FRAC_BITS + MAG_W + 1;
   localparam int REM_W = ROOT_W;

   logic [QB:0]       valid_ff;
   logic [REM_W-1:0]  rem_ff  [QB+1][3];
   logic [QB-1:0]     low_ff  [QB+1][3];
   logic [QB-1:0]     quot_ff [QB+1][3];
   root_type          root_ff [QB+1];
   logic [SIDE_W-1:0] side_ff [QB+1];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QB-1:0], in_valid};
      end
   end

   // setup: dividend m * 2^F + N/2, split into a start remainder and low bits
   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         logic [XW-1:0] xv;
         xv = (XW'(in_mag[l]) << FRAC_BITS) + XW'(in_root >> 1);
         rem_ff[0][l]  <= REM_W'(xv >> QB);
         low_ff[0][l]  <= xv[QB-1:0];
         quot_ff[0][l] <= '0;
      end
      root_ff[0] <= in_root;
      side_ff[0] <= in_side;
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [REM_W-1:0] rem_in  [3];
      logic [QB-1:0]    quot_in [3];

      // restoring step on each lane
      always_comb begin
         logic [REM_W:0] rem_sh;
         logic [REM_W:0] dvs;
         dvs = {1'b0, root_ff[k-1]};
         for (int l = 0; l < 3; l++) begin
            rem_sh = {rem_ff[k-1][l], low_ff[k-1][l][QB-1]};
            if (rem_sh >= dvs) begin
               rem_in[l]  = REM_W'(rem_sh - dvs);
               quot_in[l] = {quot_ff[k-1][l][QB-2:0], 1'b1};
            end else begin
               rem_in[l]  = rem_sh[REM_W-1:0];
               quot_in[l] = {quot_ff[k-1][l][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[k][l]  <= rem_in[l];
            quot_ff[k][l] <= quot_in[l];
            low_ff[k][l]  <= low_ff[k-1][l] << 1;
         end
         root_ff[k] <= root_ff[k-1];
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid   = valid_ff[QB];
   assign out_quot[0] = quot_ff[QB][0];
   assign out_quot[1] = quot_ff[QB][1];
   assign out_quot[2] = quot_ff[QB][2];
   assign out_side    = side_ff[QB];

endmodule

`default_nettype wire

@@ hw/rtl/pftp_back.sv @@
// ----------------------------------------------------------------------------
// pftp_back
// signed unit normal, dot product with the first point, rounding and clamps
// ----------------------------------------------------------------------------
`default_nettype none

module pftp_back
   import pftp_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int FRAC_BITS  = 14
)
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   input  wire [2:0][FRAC_BITS:0]       in_quot,
   input  wire [2:0]                    in_neg,
   input  wire                          in_degen,
   input  wire signed [COORD_BITS-1:0]  in_a_x,
   input  wire signed [COORD_BITS-1:0]  in_a_y,
   input  wire signed [COORD_BITS-1:0]  in_a_z,
   output logic                         out_valid,
   output logic signed [NORMAL_W-1:0]   out_normal_x,
   output logic signed [NORMAL_W-1:0]   out_normal_y,
   output logic signed [NORMAL_W-1:0]   out_normal_z,
   output logic signed [OFFSET_W-1:0]   out_offset_d,
   output logic                         out_degen
);

   localparam int QB = FRAC_BITS + 1;
   localparam int NW = FRAC_BITS + 2;
   localparam int MW = NW + COORD_BITS;
   localparam int PW = MW + 2;
   localparam int CW = ((NW > NORMAL_W) ? NW : NORMAL_W) + 1;
   localparam int RW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;

   localparam logic [QB-1:0]          ONE    = QB'(1) << FRAC_BITS;
   localparam logic [PW-1:0]          HALF   = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [CW-1:0]   N_HI   = CW'((2 ** (NORMAL_W - 1)) - 1);
   localparam logic signed [CW-1:0]   N_LO   = -N_HI - CW'(1);
   localparam logic [RW-1:0]          D_POS  = RW'((2 ** (OFFSET_W - 1)) - 1);
   localparam logic [RW-1:0]          D_NEG  = RW'(2 ** (OFFSET_W - 1));

   logic [BACK_STAGES-1:0]       valid_ff;
   logic [BACK_STAGES-2:0]       degen_ff;
   logic signed [NW-1:0]         n1_ff [3];
   logic signed [NW-1:0]         n2_ff [3];
   logic signed [NW-1:0]         n3_ff [3];
   logic signed [COORD_BITS-1:0] a1_ff [3];
   logic signed [MW-1:0]         prod2_ff [3];
   logic signed [PW-1:0]         p3_ff;

   logic signed [NORMAL_W-1:0]   nx_ff, ny_ff, nz_ff;
   logic signed [OFFSET_W-1:0]   d_ff;
   logic                         degen_out_ff;

   logic signed [NW-1:0]         n1_in [3];
   logic signed [NORMAL_W-1:0]   nsat_in [3];
   logic signed [OFFSET_W-1:0]   d_in;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[BACK_STAGES-2:0], in_valid};
      end
   end

   // stage 1: clamp to one and apply the sign
   always_comb begin
      logic [QB-1:0] qc;
      for (int l = 0; l < 3; l++) begin
         qc       = (in_quot[l] > ONE) ? ONE : in_quot[l];
         n1_in[l] = in_neg[l] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      end
   end

   always_ff @(posedge clock) begin
      n1_ff    <= n1_in;
      a1_ff[0] <= in_a_x;
      a1_ff[1] <= in_a_y;
      a1_ff[2] <= in_a_z;
      degen_ff <= {degen_ff[BACK_STAGES-3:0], in_degen};
   end

   // stage 2: products with the first point
   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         prod2_ff[l] <= n1_ff[l] * a1_ff[l];
      end
      n2_ff <= n1_ff;
   end

   // stage 3: dot product
   always_ff @(posedge clock) begin
      p3_ff <= PW'(prod2_ff[0]) + PW'(prod2_ff[1]) + PW'(prod2_ff[2]);
      n3_ff <= n2_ff;
   end

   // stage 4: round half away from zero, negate, clamp
   always_comb begin
      logic [PW-1:0]        pm;
      logic [PW-1:0]        rnd;
      logic [RW-1:0]        rr;
      logic signed [RW-1:0] dv;
      logic signed [CW-1:0] nw;
      pm  = p3_ff[PW-1] ? PW'(-p3_ff) : PW'(p3_ff);
      rnd = (pm + HALF) >> FRAC_BITS;
      rr  = RW'(rnd);
      if (p3_ff[PW-1]) begin
         dv = $signed((rr > D_POS) ? D_POS : rr);
      end else begin
         dv = -$signed((rr > D_NEG) ? D_NEG : rr);
      end
      d_in = dv[OFFSET_W-1:0];
      for (int l = 0; l < 3; l++) begin
         nw = CW'(n3_ff[l]);
         if (nw > N_HI) begin
            nw = N_HI;
         end else if (nw < N_LO) begin
            nw = N_LO;
         end
         nsat_in[l] = nw[NORMAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (degen_ff[BACK_STAGES-2]) begin
         nx_ff <= '0;
         ny_ff <= '0;
         nz_ff <= '0;
         d_ff  <= '0;
      end else begin
         nx_ff <= nsat_in[0];
         ny_ff <= nsat_in[1];
         nz_ff <= nsat_in[2];
         d_ff  <= d_in;
      end
      degen_out_ff <= degen_ff[BACK_STAGES-2];
   end

   assign out_valid    = valid_ff[BACK_STAGES-1];
   assign out_normal_x = nx_ff;
   assign out_normal_y = ny_ff;
   assign out_normal_z = nz_ff;
   assign out_offset_d = d_ff;
   assign out_degen    = degen_out_ff;

endmodule

`default_nettype wire

@@ hw/rtl/plane_from_three_points.sv @@
// ----------------------------------------------------------------------------
// plane_from_three_points
// plane through three points: unit normal in Q1.F and offset -(n . a)
// ----------------------------------------------------------------------------
// throughput: one point triple per cycle; busy stays low
// the pipeline length is set mostly by the 32-stage square root and the F+2 stage divider
// reset clears every valid bit; results in flight are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module plane_from_three_points
   import pftp_pkg::*;
#(
   parameter int COORD_BITS       = 24,
   parameter int NORMAL_FRAC_BITS = 14
)
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire signed [COORD_BITS-1:0]  req_a_x,
   input  wire signed [COORD_BITS-1:0]  req_a_y,
   input  wire signed [COORD_BITS-1:0]  req_a_z,
   input  wire signed [COORD_BITS-1:0]  req_b_x,
   input  wire signed [COORD_BITS-1:0]  req_b_y,
   input  wire signed [COORD_BITS-1:0]  req_b_z,
   input  wire signed [COORD_BITS-1:0]  req_c_x,
   input  wire signed [COORD_BITS-1:0]  req_c_y,
   input  wire signed [COORD_BITS-1:0]  req_c_z,
   output logic                         rsp_valid,
   output logic signed [NORMAL_W-1:0]   rsp_normal_x,
   output logic signed [NORMAL_W-1:0]   rsp_normal_y,
   output logic signed [NORMAL_W-1:0]   rsp_normal_z,
   output logic signed [OFFSET_W-1:0]   rsp_offset_d,
   output logic                         rsp_degenerate
);

   localparam int QB        = NORMAL_FRAC_BITS + 1;
   localparam int A_W       = 3 * COORD_BITS;
   localparam int DIV_SIDE  = A_W + 4;
   localparam int SQ_SIDE   = DIV_SIDE + 3 * MAG_W;
   localparam int LATENCY   = FRONT_STAGES + ROOT_W + QB + 1 + BACK_STAGES;

   logic                         fe_valid;
   sum_type                      fe_sum;
   mag_type [2:0]                fe_mag;
   logic [2:0]                   fe_neg;
   logic                         fe_degen;
   logic signed [COORD_BITS-1:0] fe_a_x, fe_a_y, fe_a_z;

   logic                         sq_valid;
   root_type                     sq_root;
   logic [SQ_SIDE-1:0]           sq_side;

   logic                         dv_valid;
   logic [2:0][QB-1:0]           dv_quot;
   logic [DIV_SIDE-1:0]          dv_side;

   // the pipeline takes a transfer on every cycle
   assign busy = 1'b0;

   pftp_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .a_x       (req_a_x),
      .a_y       (req_a_y),
      .a_z       (req_a_z),
      .b_x       (req_b_x),
      .b_y       (req_b_y),
      .b_z       (req_b_z),
      .c_x       (req_c_x),
      .c_y       (req_c_y),
      .c_z       (req_c_z),
      .out_valid (fe_valid),
      .out_sum   (fe_sum),
      .out_mag   (fe_mag),
      .out_neg   (fe_neg),
      .out_degen (fe_degen),
      .out_a_x   (fe_a_x),
      .out_a_y   (fe_a_y),
      .out_a_z   (fe_a_z)
   );

   // norm of the shifted cross product
   pftp_isqrt #(
      .SIDE_W (SQ_SIDE)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_sum    (fe_sum),
      .in_side   ({fe_mag[2], fe_mag[1], fe_mag[0], fe_neg, fe_degen,
                   fe_a_x, fe_a_y, fe_a_z}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // component over norm, rounded
   pftp_div #(
      .FRAC_BITS (NORMAL_FRAC_BITS),
      .SIDE_W    (DIV_SIDE)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_mag    (sq_side[SQ_SIDE-1:DIV_SIDE]),
      .in_side   (sq_side[DIV_SIDE-1:0]),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   pftp_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (NORMAL_FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (dv_valid),
      .in_quot      (dv_quot),
      .in_neg       (dv_side[A_W+3:A_W+1]),
      .in_degen     (dv_side[A_W]),
      .in_a_x       ($signed(dv_side[3*COORD_BITS-1:2*COORD_BITS])),
      .in_a_y       ($signed(dv_side[2*COORD_BITS-1:COORD_BITS])),
      .in_a_z       ($signed(dv_side[COORD_BITS-1:0])),
      .out_valid    (rsp_valid),
      .out_normal_x (rsp_normal_x),
      .out_normal_y (rsp_normal_y),
      .out_normal_z (rsp_normal_z),
      .out_offset_d (rsp_offset_d),
      .out_degen    (rsp_degenerate)
   );

   // every transfer in gives exactly one result after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("result missing after accepted transfer");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without matching transfer");

   // degenerate results carry zeros
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0 &&
         rsp_offset_d == '0)
      else $error("degenerate result with nonzero fields");

   // a real plane never has a zero normal
   a_normal_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
      else $error("zero normal on a non-degenerate result");

endmodule

`default_nettype wire
